/* rtl/tcfc_pkg.sv */
// Shared types, constants and helpers for the timecode / frame count converter.
// Holds the request and response payloads, the rate mode codes and the reciprocal
// constants that the divide-by-constant stages use. No dependencies.
package tcfc_pkg;

	// Field widths
	localparam int FC_W   = 22;
	localparam int HR_W   = 5;
	localparam int MS_W   = 6;
	localparam int FR_W   = 5;
	localparam int MODE_W = 3;

	// Nominal (drop-free) frame count, wide enough for an expanded drop-frame count
	localparam int N_W = 23;

	// Pipeline depth
	localparam int STAGES = 8;
	typedef logic [STAGES-1:0] stage_en_t;

	// Operations
	typedef enum logic {
		OP_TC2FC = 1'b0,
		OP_FC2TC = 1'b1
	} op_t;

	// Rate mode register codes
	localparam logic [MODE_W-1:0] MODE_24     = 3'd0;
	localparam logic [MODE_W-1:0] MODE_25     = 3'd1;
	localparam logic [MODE_W-1:0] MODE_30ND   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_30DF   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_23976  = 3'd4;
	localparam logic [MODE_W-1:0] MODE_24975  = 3'd5;
	localparam logic [MODE_W-1:0] MODE_2997ND = 3'd6;
	localparam logic [MODE_W-1:0] MODE_2997DF = 3'd7;

	typedef enum logic [1:0] {
		NOM_24,
		NOM_25,
		NOM_30
	} nom_t;

	typedef struct packed {
		nom_t nom;
		logic df;
	} mode_t;

	typedef struct packed {
		op_t   op;
		mode_t mode;
	} ctl_t;

	typedef struct packed {
		op_t             opcode;
		logic [HR_W-1:0] in_hours;
		logic [MS_W-1:0] in_minutes;
		logic [MS_W-1:0] in_seconds;
		logic [FR_W-1:0] in_frames;
		logic [FC_W-1:0] in_frame_count;
	} req_t;

	typedef struct packed {
		logic [FC_W-1:0] out_frame_count;
		logic [HR_W-1:0] out_hours;
		logic [MS_W-1:0] out_minutes;
		logic [MS_W-1:0] out_seconds;
		logic [FR_W-1:0] out_frames;
	} rsp_t;

	// Timecode constants
	localparam int RATE_24       = 24;
	localparam int RATE_25       = 25;
	localparam int RATE_30       = 30;
	localparam int SEC_PER_MIN   = 60;
	localparam int SEC_PER_HOUR  = 3600;
	localparam int MIN_PER_HOUR  = 60;
	localparam int HOURS_PER_DAY = 24;
	localparam int TEN_MIN       = 17982; // drop-frame frames in ten minutes
	localparam int FIRST_MIN     = 1800;  // first minute of a block keeps all frames
	localparam int OTHER_MIN     = 1798;  // other minutes lose two frames
	localparam int NOM_TEN_MIN   = 18000; // nominal frames in ten minutes at 30
	localparam int MIN_PER_BLOCK = 10;

	// Exact floor division by reciprocal: q = (x * R) >> S, R = 2^S / d + 1,
	// S = width(x) + ceil(log2(d))
	localparam int          TEN_SH    = 37;
	localparam logic [63:0] TEN_RCP_L = (64'd1 << TEN_SH) / 64'd17982 + 64'd1;
	localparam logic [22:0] TEN_RCP   = TEN_RCP_L[22:0];

	localparam int          OTHER_SH    = 25;
	localparam logic [63:0] OTHER_RCP_L = (64'd1 << OTHER_SH) / 64'd1798 + 64'd1;
	localparam logic [14:0] OTHER_RCP   = OTHER_RCP_L[14:0];

	localparam int          NOM_SH     = 28;
	localparam logic [63:0] R24_RCP_L  = (64'd1 << NOM_SH) / 64'd24 + 64'd1;
	localparam logic [63:0] R25_RCP_L  = (64'd1 << NOM_SH) / 64'd25 + 64'd1;
	localparam logic [63:0] R30_RCP_L  = (64'd1 << NOM_SH) / 64'd30 + 64'd1;

	localparam int          MIN_SH    = 24;
	localparam logic [63:0] MIN_RCP_L = (64'd1 << MIN_SH) / 64'd60 + 64'd1;
	localparam logic [18:0] MIN_RCP   = MIN_RCP_L[18:0];

	localparam int          HR_SH    = 18;
	localparam logic [63:0] HR_RCP_L = (64'd1 << HR_SH) / 64'd60 + 64'd1;
	localparam logic [12:0] HR_RCP   = HR_RCP_L[12:0];

	localparam int          DIV10_SH    = 15;
	localparam logic [63:0] DIV10_RCP_L = (64'd1 << DIV10_SH) / 64'd10 + 64'd1;
	localparam logic [11:0] DIV10_RCP   = DIV10_RCP_L[11:0];

	function automatic mode_t mode_decode(input logic [MODE_W-1:0] mode);
		mode_t m;
		m.df = (mode == MODE_30DF) || (mode == MODE_2997DF);
		case (mode)
			MODE_24, MODE_23976: m.nom = NOM_24;
			MODE_25, MODE_24975: m.nom = NOM_25;
			default:             m.nom = NOM_30;
		endcase
		return m;
	endfunction

	function automatic logic [4:0] nom_value(input nom_t nom);
		logic [4:0] v;
		case (nom)
			NOM_24:  v = 5'(RATE_24);
			NOM_25:  v = 5'(RATE_25);
			default: v = 5'(RATE_30);
		endcase
		return v;
	endfunction

	function automatic logic [23:0] nom_recip(input nom_t nom);
		logic [23:0] r;
		case (nom)
			NOM_24:  r = R24_RCP_L[23:0];
			NOM_25:  r = R25_RCP_L[23:0];
			default: r = R30_RCP_L[23:0];
		endcase
		return r;
	endfunction

endpackage

/* rtl/tcfc_if.sv */
// Valid/ready channel carrying one request or response payload.
// Payload type is set per instance; used with tcfc_pkg::req_t and rsp_t.
interface tcfc_if #(parameter type data_t = logic);
	logic  valid;
	logic  ready;
	data_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

/* rtl/tcfc_tc2fc.sv */
// Timecode to frame count lane, stages 1 to 3.
// Depends on tcfc_pkg for field widths, rate helpers and stage enables.
module tcfc_tc2fc (
	input  logic                   clk,
	input  tcfc_pkg::stage_en_t    en,
	input  tcfc_pkg::req_t         req,
	input  tcfc_pkg::mode_t        mode_s1,
	input  tcfc_pkg::mode_t        mode_s2,
	output logic [tcfc_pkg::FC_W-1:0] fc_s3
);
	import tcfc_pkg::*;

	localparam int SUM_W = 17;
	localparam int TM_W  = 11;
	localparam int TMQ_W = 8;
	localparam int TMP_W = TM_W + 12;

	logic [SUM_W-1:0] sec_sum_s1;
	logic [TM_W-1:0]  tm_s1;
	logic [FR_W-1:0]  f_s1;
	logic [FC_W-1:0]  base_s2;
	logic [TM_W-1:0]  tm_s2;
	logic [TMQ_W-1:0] tmq_s2;
	logic [TMP_W-1:0] tm_prod;
	logic [TM_W:0]    drop;

	// Divide total minutes by ten
	assign tm_prod = TMP_W'(tm_s1) * TMP_W'(DIV10_RCP);
	// Two frames dropped per minute except every tenth
	assign drop = {tm_s2 - TM_W'(tmq_s2), 1'b0};

	// Stage 1: total seconds and total minutes
	always_ff @(posedge clk) begin
		if (en[0]) begin
			sec_sum_s1 <= SUM_W'(req.in_hours) * SUM_W'(SEC_PER_HOUR)
				+ SUM_W'(req.in_minutes) * SUM_W'(SEC_PER_MIN) + SUM_W'(req.in_seconds);
			tm_s1 <= TM_W'(req.in_hours) * TM_W'(MIN_PER_HOUR) + TM_W'(req.in_minutes);
			f_s1  <= req.in_frames;
		end
	end

	// Stage 2: scale seconds by the nominal rate
	always_ff @(posedge clk) begin
		if (en[1]) begin
			base_s2 <= FC_W'(sec_sum_s1) * FC_W'(nom_value(mode_s1.nom)) + FC_W'(f_s1);
			tm_s2   <= tm_s1;
			tmq_s2  <= tm_prod[TMP_W-1:DIV10_SH];
		end
	end

	// Stage 3: take off dropped frames
	always_ff @(posedge clk) begin
		if (en[2]) begin
			fc_s3 <= mode_s2.df ? base_s2 - FC_W'(drop) : base_s2;
		end
	end

endmodule

/* rtl/tcfc_df_expand.sv */
// Drop-frame expansion, stages 1 to 4: maps a frame count to a nominal count
// with dropped frame numbers restored. Depends on tcfc_pkg.
module tcfc_df_expand (
	input  logic                      clk,
	input  tcfc_pkg::stage_en_t       en,
	input  logic [tcfc_pkg::FC_W-1:0] frame_count,
	input  logic                      df_s3,
	output logic [tcfc_pkg::N_W-1:0]  n_s4
);
	import tcfc_pkg::*;

	localparam int BLK_W  = 8;
	localparam int REM_W  = 15;
	localparam int OFF_W  = 14;
	localparam int ONES_W = 4;
	localparam int TP_W   = FC_W + 23;
	localparam int OP_W   = OFF_W + 15;

	logic [TP_W-1:0]   ten_prod;
	logic [FC_W-1:0]   rem_full;
	logic [REM_W-1:0]  off;
	logic [OP_W-1:0]   other_prod;
	logic [ONES_W-1:0] ones_q1;

	logic [FC_W-1:0]   fc_s1, fc_s2, fc_s3;
	logic [BLK_W-1:0]  blk_s1, blk_s2, blk_s3;
	logic [REM_W-1:0]  rem_s2, rem_s3;
	logic [ONES_W-1:0] ones_s3;

	// Ten-minute block index
	assign ten_prod = TP_W'(frame_count) * TP_W'(TEN_RCP);
	assign rem_full = fc_s1 - FC_W'(blk_s1) * FC_W'(TEN_MIN);
	// Minute within the block past the first one
	assign off        = rem_s2 - REM_W'(FIRST_MIN);
	assign other_prod = OP_W'(off[OFF_W-1:0]) * OP_W'(OTHER_RCP);
	assign ones_q1    = other_prod[OP_W-1:OTHER_SH] + ONES_W'(1);

	// Stage 1: block index
	always_ff @(posedge clk) begin
		if (en[0]) begin
			fc_s1  <= frame_count;
			blk_s1 <= ten_prod[TP_W-1:TEN_SH];
		end
	end

	// Stage 2: remainder within the block
	always_ff @(posedge clk) begin
		if (en[1]) begin
			fc_s2  <= fc_s1;
			blk_s2 <= blk_s1;
			rem_s2 <= rem_full[REM_W-1:0];
		end
	end

	// Stage 3: minute within the block
	always_ff @(posedge clk) begin
		if (en[2]) begin
			fc_s3   <= fc_s2;
			blk_s3  <= blk_s2;
			rem_s3  <= rem_s2;
			ones_s3 <= (rem_s2 < REM_W'(FIRST_MIN)) ? '0 : ones_q1;
		end
	end

	// Stage 4: restore two frames per dropped minute, or pass the count through
	always_ff @(posedge clk) begin
		if (en[3]) begin
			n_s4 <= df_s3 ? N_W'(blk_s3) * N_W'(NOM_TEN_MIN) + N_W'(rem_s3)
				+ N_W'({ones_s3, 1'b0}) : N_W'(fc_s3);
		end
	end

endmodule

/* rtl/tcfc_split.sv */
// Nominal count to hours, minutes, seconds and frames, stages 5 to 8.
// Depends on tcfc_pkg for reciprocal constants and rate helpers.
module tcfc_split (
	input  logic                      clk,
	input  tcfc_pkg::stage_en_t       en,
	input  logic [tcfc_pkg::N_W-1:0]  n_s4,
	input  tcfc_pkg::nom_t            nom_s4,
	input  tcfc_pkg::nom_t            nom_s5,
	input  logic                      clear_s7,
	output logic [tcfc_pkg::HR_W-1:0] hh_s8,
	output logic [tcfc_pkg::MS_W-1:0] mm_s8,
	output logic [tcfc_pkg::MS_W-1:0] ss_s8,
	output logic [tcfc_pkg::FR_W-1:0] ff_s8
);
	import tcfc_pkg::*;

	localparam int SECS_W = 18;
	localparam int MINS_W = 12;
	localparam int HRS_W  = 6;
	localparam int SP_W   = N_W + 24;
	localparam int MP_W   = SECS_W + 19;
	localparam int HP_W   = MINS_W + 13;

	logic [SP_W-1:0]   secs_prod;
	logic [N_W-1:0]    ff_full;
	logic [MP_W-1:0]   mins_prod;
	logic [SECS_W-1:0] ss_full;
	logic [HP_W-1:0]   hrs_prod;
	logic [MINS_W-1:0] mm_full;
	logic [HR_W-1:0]   hh;

	logic [N_W-1:0]    n_s5;
	logic [SECS_W-1:0] secs_s5, secs_s6;
	logic [FR_W-1:0]   ff_s6, ff_s7;
	logic [MINS_W-1:0] mins_s6, mins_s7;
	logic [MS_W-1:0]   ss_s7;
	logic [HRS_W-1:0]  hrs_s7;

	assign secs_prod = SP_W'(n_s4) * SP_W'(nom_recip(nom_s4));
	assign ff_full   = n_s5 - N_W'(secs_s5) * N_W'(nom_value(nom_s5));
	assign mins_prod = MP_W'(secs_s5) * MP_W'(MIN_RCP);
	assign ss_full   = secs_s6 - SECS_W'(mins_s6) * SECS_W'(SEC_PER_MIN);
	assign hrs_prod  = HP_W'(mins_s6) * HP_W'(HR_RCP);
	assign mm_full   = mins_s7 - MINS_W'(hrs_s7) * MINS_W'(MIN_PER_HOUR);

	// Wrap hours to a day; they never reach three days
	always_comb begin
		if (hrs_s7 >= HRS_W'(2 * HOURS_PER_DAY)) begin
			hh = HR_W'(hrs_s7 - HRS_W'(2 * HOURS_PER_DAY));
		end else if (hrs_s7 >= HRS_W'(HOURS_PER_DAY)) begin
			hh = HR_W'(hrs_s7 - HRS_W'(HOURS_PER_DAY));
		end else begin
			hh = HR_W'(hrs_s7);
		end
	end

	// Stage 5: total seconds
	always_ff @(posedge clk) begin
		if (en[4]) begin
			n_s5    <= n_s4;
			secs_s5 <= secs_prod[SP_W-2:NOM_SH];
		end
	end

	// Stage 6: frames and total minutes
	always_ff @(posedge clk) begin
		if (en[5]) begin
			ff_s6   <= ff_full[FR_W-1:0];
			secs_s6 <= secs_s5;
			mins_s6 <= mins_prod[MP_W-2:MIN_SH];
		end
	end

	// Stage 7: seconds and total hours
	always_ff @(posedge clk) begin
		if (en[6]) begin
			ff_s7   <= ff_s6;
			ss_s7   <= ss_full[MS_W-1:0];
			mins_s7 <= mins_s6;
			hrs_s7  <= hrs_prod[HP_W-2:HR_SH];
		end
	end

	// Stage 8: minutes and hours; zero the fields for the other operation
	always_ff @(posedge clk) begin
		if (en[7]) begin
			hh_s8 <= clear_s7 ? '0 : hh;
			mm_s8 <= clear_s7 ? '0 : mm_full[MS_W-1:0];
			ss_s8 <= clear_s7 ? '0 : ss_s7;
			ff_s8 <= clear_s7 ? '0 : ff_s7;
		end
	end

endmodule

/* rtl/timecode_frame_converter.sv */
// SMPTE timecode / frame count converter, top level.
// Depends on tcfc_pkg, tcfc_if, tcfc_tc2fc, tcfc_df_expand and tcfc_split.
//
// Requests arrive on req (valid/ready, payload tcfc_pkg::req_t); each gives one
// response on rsp (payload tcfc_pkg::rsp_t). Opcode OP_TC2FC turns a timecode
// into a frame count, OP_FC2TC splits a frame count into a timecode; the fields
// of the other operation read as zero. cfg_we/cfg_wdata write the rate mode;
// write it only while no request is in flight.
//
// The block takes one request per cycle unless a stalled rsp has backed the
// pipeline up to stage one: it is an eight-stage pipeline, the response held
// in the last stage register.
// When rsp is stalled, stages fill one by one behind the held response; req
// stays ready while stage one is empty or moving, so nothing is lost or
// repeated. Reset empties the pipeline and sets the mode to 30 non-drop.
module timecode_frame_converter (
	input  logic                          clk,
	input  logic                          arst_n,
	tcfc_if.sink                          req,
	tcfc_if.source                        rsp,
	input  logic                          cfg_we,
	input  logic [tcfc_pkg::MODE_W-1:0]   cfg_wdata
);
	import tcfc_pkg::*;

	logic [MODE_W-1:0] mode_q;
	logic [STAGES-1:0] vld_q;
	stage_en_t         en;
	ctl_t              ctl_in;
	ctl_t              ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6, ctl_s7;
	logic [FC_W-1:0]   fc_s3, fc_s4, fc_s5, fc_s6, fc_s7, fc_s8;
	logic [N_W-1:0]    n_s4;
	logic [HR_W-1:0]   hh_s8;
	logic [MS_W-1:0]   mm_s8, ss_s8;
	logic [FR_W-1:0]   ff_s8;

	// Rate mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_30ND;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	// Advance a stage when it is empty or the next one advances
	always_comb begin
		en[STAGES-1] = !vld_q[STAGES-1] || rsp.ready;
		for (int i = STAGES - 2; i >= 0; i--) begin
			en[i] = !vld_q[i] || en[i+1];
		end
	end

	assign req.ready = en[0];

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= req.valid;
			end
			for (int i = 1; i < STAGES; i++) begin
				if (en[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	// Opcode and decoded mode travel with the request
	assign ctl_in.op   = req.data.opcode;
	assign ctl_in.mode = mode_decode(mode_q);

	always_ff @(posedge clk) begin
		if (en[0]) ctl_s1 <= ctl_in;
		if (en[1]) ctl_s2 <= ctl_s1;
		if (en[2]) ctl_s3 <= ctl_s2;
		if (en[3]) ctl_s4 <= ctl_s3;
		if (en[4]) ctl_s5 <= ctl_s4;
		if (en[5]) ctl_s6 <= ctl_s5;
		if (en[6]) ctl_s7 <= ctl_s6;
	end

	// Hold the frame count result until the last stage; zero it for the split
	always_ff @(posedge clk) begin
		if (en[3]) fc_s4 <= fc_s3;
		if (en[4]) fc_s5 <= fc_s4;
		if (en[5]) fc_s6 <= fc_s5;
		if (en[6]) fc_s7 <= fc_s6;
		if (en[7]) fc_s8 <= (ctl_s7.op == OP_TC2FC) ? fc_s7 : '0;
	end

	tcfc_tc2fc u_tc2fc (
		.clk     (clk),
		.en      (en),
		.req     (req.data),
		.mode_s1 (ctl_s1.mode),
		.mode_s2 (ctl_s2.mode),
		.fc_s3   (fc_s3)
	);

	tcfc_df_expand u_df_expand (
		.clk         (clk),
		.en          (en),
		.frame_count (req.data.in_frame_count),
		.df_s3       (ctl_s3.mode.df),
		.n_s4        (n_s4)
	);

	tcfc_split u_split (
		.clk      (clk),
		.en       (en),
		.n_s4     (n_s4),
		.nom_s4   (ctl_s4.mode.nom),
		.nom_s5   (ctl_s5.mode.nom),
		.clear_s7 (ctl_s7.op == OP_TC2FC),
		.hh_s8    (hh_s8),
		.mm_s8    (mm_s8),
		.ss_s8    (ss_s8),
		.ff_s8    (ff_s8)
	);

	// Response
	assign rsp.valid                = vld_q[STAGES-1];
	assign rsp.data.out_frame_count = fc_s8;
	assign rsp.data.out_hours       = hh_s8;
	assign rsp.data.out_minutes     = mm_s8;
	assign rsp.data.out_seconds     = ss_s8;
	assign rsp.data.out_frames      = ff_s8;

endmodule
